[hw/rtl/bst_pkg.sv]
// Shared types, constants and helpers for the byte stream tokenizer.
`default_nettype none

package bst_pkg;

  localparam int POS_W    = 32;
  localparam int LEN_W    = 16;
  localparam int LINE_W   = 32;
  localparam int KIND_W   = 5;
  localparam int BYTE_W   = 8;
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);
  localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

  typedef enum logic [KIND_W-1:0] {
    K_IDENT    = 5'd0,
    K_NUMBER   = 5'd1,
    K_STRING   = 5'd2,
    K_COMMA    = 5'd3,
    K_EQ       = 5'd4,
    K_EQEQ     = 5'd5,
    K_GT       = 5'd6,
    K_GE       = 5'd7,
    K_LT       = 5'd8,
    K_LE       = 5'd9,
    K_MINUS    = 5'd10,
    K_LPAREN   = 5'd11,
    K_RPAREN   = 5'd12,
    K_PERCENT  = 5'd13,
    K_PLUS     = 5'd14,
    K_PLUSPLUS = 5'd15,
    K_SEMI     = 5'd16,
    K_SLASH    = 5'd17,
    K_STAR     = 5'd18,
    K_EOF      = 5'd19,
    K_BAD      = 5'd20,
    K_OPENSTR  = 5'd21
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t          kind;
    logic [POS_W-1:0]   start;
    logic [LEN_W-1:0]   len;
    logic [LINE_W-1:0]  line;
    logic               last;
  } tok_t;

  // Up to two tokens produced by one source byte; tok0 is always filled first.
  typedef struct packed {
    logic [1:0] num;
    tok_t       tok0;
    tok_t       tok1;
  } scan_out_t;

  localparam logic [BYTE_W-1:0] CH_NUL    = 8'h00;
  localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
  localparam logic [BYTE_W-1:0] CH_NL     = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
  localparam logic [BYTE_W-1:0] CH_HASH   = 8'h23;
  localparam logic [BYTE_W-1:0] CH_PCT    = 8'h25;
  localparam logic [BYTE_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [BYTE_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [BYTE_W-1:0] CH_PLUS   = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_SLASH  = 8'h2F;
  localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE   = 8'h39;
  localparam logic [BYTE_W-1:0] CH_SEMI   = 8'h3B;
  localparam logic [BYTE_W-1:0] CH_LT     = 8'h3C;
  localparam logic [BYTE_W-1:0] CH_EQ     = 8'h3D;
  localparam logic [BYTE_W-1:0] CH_GT     = 8'h3E;
  localparam logic [BYTE_W-1:0] CH_UC_A   = 8'h41;
  localparam logic [BYTE_W-1:0] CH_UC_Z   = 8'h5A;
  localparam logic [BYTE_W-1:0] CH_UNDER  = 8'h5F;
  localparam logic [BYTE_W-1:0] CH_LC_A   = 8'h61;
  localparam logic [BYTE_W-1:0] CH_LC_Z   = 8'h7A;

  function automatic logic is_letter(logic [BYTE_W-1:0] c);
    return ((c >= CH_LC_A) && (c <= CH_LC_Z)) || ((c >= CH_UC_A) && (c <= CH_UC_Z)) ||
           (c == CH_UNDER);
  endfunction

  function automatic logic is_digit(logic [BYTE_W-1:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic tok_t mk_tok(tok_kind_t k, logic [POS_W-1:0] s,
                                  logic [LEN_W-1:0] l, logic [LINE_W-1:0] ln);
    tok_t t;
    t.kind  = k;
    t.start = s;
    t.len   = l;
    t.line  = ln;
    t.last  = 1'b0;
    return t;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/bst_scan.sv]
// Scanner state machine: turns one source byte into zero, one or two tokens.
`default_nettype none

module bst_scan (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       step,
  input  wire logic [bst_pkg::BYTE_W-1:0] c,
  output bst_pkg::scan_out_t              res
);

  typedef enum logic [3:0] {
    M_IDLE, M_IDENT, M_NUMBER, M_STRING, M_COMMENT,
    M_PEQ, M_PGT, M_PLT, M_PPLUS, M_HALT
  } mode_t;

  mode_t                          mode, mode_next;
  logic [bst_pkg::POS_W-1:0]      pos, pos_next;
  logic [bst_pkg::POS_W-1:0]      tbegin, tbegin_next;
  logic [bst_pkg::LEN_W-1:0]      count, count_next;
  logic [bst_pkg::LINE_W-1:0]     line, line_next;
  logic [bst_pkg::LEN_W-1:0]      count_inc;

  logic                           disp;
  logic                           d_emit;
  bst_pkg::tok_t                  d_tok;
  logic [bst_pkg::BYTE_W-1:0]     want;
  bst_pkg::tok_kind_t             k1, k2;

  assign count_inc = (count == '1) ? count : count + bst_pkg::LEN_W'(1);

  always_comb begin
    mode_next   = mode;
    pos_next    = pos;
    tbegin_next = tbegin;
    count_next  = count;
    line_next   = line;
    res         = '0;
    disp        = 1'b0;
    d_emit      = 1'b0;
    d_tok       = '0;
    want        = bst_pkg::CH_EQ;
    k1          = bst_pkg::K_EQ;
    k2          = bst_pkg::K_EQEQ;

    unique case (mode)
      M_PGT: begin
        k1 = bst_pkg::K_GT;
        k2 = bst_pkg::K_GE;
      end
      M_PLT: begin
        k1 = bst_pkg::K_LT;
        k2 = bst_pkg::K_LE;
      end
      M_PPLUS: begin
        want = bst_pkg::CH_PLUS;
        k1   = bst_pkg::K_PLUS;
        k2   = bst_pkg::K_PLUSPLUS;
      end
      default: ;
    endcase

    if (step && (mode != M_HALT)) begin
      pos_next = pos + bst_pkg::POS_W'(1);
      unique case (mode)
        M_IDENT: begin
          if (bst_pkg::is_letter(c) || bst_pkg::is_digit(c)) begin
            count_next = count_inc;
          end else begin
            res.tok0 = bst_pkg::mk_tok(bst_pkg::K_IDENT, tbegin, count, line);
            res.num  = 2'd1;
            disp     = 1'b1;
          end
        end
        M_NUMBER: begin
          if (bst_pkg::is_digit(c)) begin
            count_next = count_inc;
          end else begin
            res.tok0 = bst_pkg::mk_tok(bst_pkg::K_NUMBER, tbegin, count, line);
            res.num  = 2'd1;
            disp     = 1'b1;
          end
        end
        M_STRING: begin
          if (c == bst_pkg::CH_QUOTE) begin
            res.tok0  = bst_pkg::mk_tok(bst_pkg::K_STRING, tbegin, count, line);
            res.num   = 2'd1;
            mode_next = M_IDLE;
          end else if (c == bst_pkg::CH_NUL) begin
            res.tok0  = bst_pkg::mk_tok(bst_pkg::K_OPENSTR, tbegin, count, line);
            res.num   = 2'd1;
            mode_next = M_HALT;
          end else begin
            count_next = count_inc;
          end
        end
        M_COMMENT: begin
          if (c == bst_pkg::CH_NL) begin
            line_next = line + bst_pkg::LINE_W'(1);
            mode_next = M_IDLE;
          end else if (c == bst_pkg::CH_NUL) begin
            res.tok0  = bst_pkg::mk_tok(bst_pkg::K_EOF, pos, bst_pkg::LEN_W'(1), line);
            res.num   = 2'd1;
            mode_next = M_HALT;
          end
        end
        M_PEQ, M_PGT, M_PLT, M_PPLUS: begin
          res.num = 2'd1;
          if (c == want) begin
            res.tok0  = bst_pkg::mk_tok(k2, tbegin, bst_pkg::LEN_W'(2), line);
            mode_next = M_IDLE;
          end else begin
            res.tok0 = bst_pkg::mk_tok(k1, tbegin, bst_pkg::LEN_W'(1), line);
            disp     = 1'b1;
          end
        end
        default: disp = 1'b1;
      endcase
    end

    // The byte that ended a token (or arrived while idle) starts afresh here.
    if (disp) begin
      mode_next = M_IDLE;
      if (bst_pkg::is_letter(c)) begin
        mode_next   = M_IDENT;
        tbegin_next = pos;
        count_next  = bst_pkg::LEN_W'(1);
      end else if (bst_pkg::is_digit(c)) begin
        mode_next   = M_NUMBER;
        tbegin_next = pos;
        count_next  = bst_pkg::LEN_W'(1);
      end else begin
        unique case (c)
          bst_pkg::CH_SPACE, bst_pkg::CH_TAB, bst_pkg::CH_CR: ;
          bst_pkg::CH_NL: line_next = line + bst_pkg::LINE_W'(1);
          bst_pkg::CH_QUOTE: begin
            mode_next   = M_STRING;
            tbegin_next = pos + bst_pkg::POS_W'(1);
            count_next  = '0;
          end
          bst_pkg::CH_HASH: mode_next = M_COMMENT;
          bst_pkg::CH_EQ: begin
            mode_next   = M_PEQ;
            tbegin_next = pos;
          end
          bst_pkg::CH_GT: begin
            mode_next   = M_PGT;
            tbegin_next = pos;
          end
          bst_pkg::CH_LT: begin
            mode_next   = M_PLT;
            tbegin_next = pos;
          end
          bst_pkg::CH_PLUS: begin
            mode_next   = M_PPLUS;
            tbegin_next = pos;
          end
          bst_pkg::CH_COMMA: begin
            d_emit = 1'b1;
            d_tok  = bst_pkg::mk_tok(bst_pkg::K_COMMA, pos, bst_pkg::LEN_W'(1), line);
          end
          bst_pkg::CH_MINUS: begin
            d_emit = 1'b1;
            d_tok  = bst_pkg::mk_tok(bst_pkg::K_MINUS, pos, bst_pkg::LEN_W'(1), line);
          end
          bst_pkg::CH_LPAREN: begin
            d_emit = 1'b1;
            d_tok  = bst_pkg::mk_tok(bst_pkg::K_LPAREN, pos, bst_pkg::LEN_W'(1), line);
          end
          bst_pkg::CH_RPAREN: begin
            d_emit = 1'b1;
            d_tok  = bst_pkg::mk_tok(bst_pkg::K_RPAREN, pos, bst_pkg::LEN_W'(1), line);
          end
          bst_pkg::CH_PCT: begin
            d_emit = 1'b1;
            d_tok  = bst_pkg::mk_tok(bst_pkg::K_PERCENT, pos, bst_pkg::LEN_W'(1), line);
          end
          bst_pkg::CH_SEMI: begin
            d_emit = 1'b1;
            d_tok  = bst_pkg::mk_tok(bst_pkg::K_SEMI, pos, bst_pkg::LEN_W'(1), line);
          end
          bst_pkg::CH_SLASH: begin
            d_emit = 1'b1;
            d_tok  = bst_pkg::mk_tok(bst_pkg::K_SLASH, pos, bst_pkg::LEN_W'(1), line);
          end
          bst_pkg::CH_STAR: begin
            d_emit = 1'b1;
            d_tok  = bst_pkg::mk_tok(bst_pkg::K_STAR, pos, bst_pkg::LEN_W'(1), line);
          end
          bst_pkg::CH_NUL: begin
            d_emit    = 1'b1;
            d_tok     = bst_pkg::mk_tok(bst_pkg::K_EOF, pos, bst_pkg::LEN_W'(1), line);
            mode_next = M_HALT;
          end
          default: begin
            d_emit    = 1'b1;
            d_tok     = bst_pkg::mk_tok(bst_pkg::K_BAD, pos, bst_pkg::LEN_W'(1), line);
            mode_next = M_HALT;
          end
        endcase
      end
      if (d_emit) begin
        if (res.num == 2'd0) begin
          res.tok0 = d_tok;
        end else begin
          res.tok1 = d_tok;
        end
        res.num = res.num + 2'd1;
      end
    end

    if (res.num == 2'd1) begin
      res.tok0.last = 1'b1;
    end else if (res.num == 2'd2) begin
      res.tok1.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= M_IDLE;
      pos    <= '0;
      tbegin <= '0;
      count  <= '0;
      line   <= '0;
    end else begin
      mode   <= mode_next;
      pos    <= pos_next;
      tbegin <= tbegin_next;
      count  <= count_next;
      line   <= line_next;
    end
  end

  a_halt_silent: assert property (@(posedge clk) disable iff (rst)
    (mode == M_HALT) |-> (res.num == 2'd0 && mode_next == M_HALT && pos_next == pos))
    else $error("scanner produced output or moved while halted");

  a_two_tokens: assert property (@(posedge clk) disable iff (rst)
    (res.num == 2'd2) |-> (res.tok1.last && !res.tok0.last))
    else $error("last flag misplaced on a two-token step");

  a_num_range: assert property (@(posedge clk) disable iff (rst)
    res.num != 2'd3)
    else $error("scanner produced more than two tokens");

  a_pos_moves: assert property (@(posedge clk) disable iff (rst)
    (step && mode != M_HALT) |=> (pos == $past(pos) + bst_pkg::POS_W'(1)))
    else $error("byte position did not advance on a scanned byte");

endmodule

`default_nettype wire

[hw/rtl/bst_outq.sv]
// Token queue: takes up to two tokens a cycle, hands out one token per item.
`default_nettype none

module bst_outq (
  input  wire logic               clk,
  input  wire logic               rst,
  input  bst_pkg::scan_out_t      wr,
  output logic                    room,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output bst_pkg::tok_t           out_tok
);

  bst_pkg::tok_t                  mem [bst_pkg::OQ_DEPTH];
  logic [bst_pkg::OQ_AW-1:0]      wptr, rptr;
  logic [bst_pkg::OQ_CW-1:0]      count;
  logic                           rd;

  assign out_valid = (count != '0);
  assign out_tok   = mem[rptr];
  assign rd        = out_valid && out_ready;
  // Two free slots are needed since one byte can yield two tokens.
  assign room      = (count <= bst_pkg::OQ_CW'(bst_pkg::OQ_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (wr.num != 2'd0) begin
      mem[wptr] <= wr.tok0;
    end
    if (wr.num == 2'd2) begin
      mem[wptr + bst_pkg::OQ_AW'(1)] <= wr.tok1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + bst_pkg::OQ_AW'(wr.num);
      if (rd) begin
        rptr <= rptr + bst_pkg::OQ_AW'(1);
      end
      count <= count + bst_pkg::OQ_CW'(wr.num) - bst_pkg::OQ_CW'(rd);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (wr.num != 2'd0) |-> room)
    else $error("token queue written without room");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= bst_pkg::OQ_CW'(bst_pkg::OQ_DEPTH))
    else $error("token queue count out of range");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (wptr - rptr) == bst_pkg::OQ_AW'(count))
    else $error("token queue pointers disagree with count");

endmodule

`default_nettype wire

[hw/rtl/byte_stream_tokenizer_core.sv]
// Byte stream tokenizer top level: input register, scanner and token queue.
//
// Usage: source bytes enter one per item on the in_valid/in_ready channel
// (src_byte). Tokens leave one per item on the out_valid/out_ready channel
// with tok_kind, start_pos, lexeme_len, line_num and last_of_run; a byte
// can produce zero, one or two tokens, and last_of_run marks the final
// token caused by a byte.
// Path: a byte accepted at in is held in the input register, scanned, and
// its tokens are written into the queue and offered once it is drained.
// Throughput: one byte per cycle while the queue has room; the scanner
// steps one byte per cycle when it has room and the token queue (four
// entries) needs two free slots before a byte is scanned, so bursts of
// two-token bytes are limited by the one token per cycle output port.
// Reset: synchronous, clears the scanner to idle with position, line and
// length counters at zero and empties the queue. After an EOF, bad symbol
// or open string token the scanner halts: further bytes are accepted and
// dropped until the next reset.
// Stall: when out_ready stays low the queue fills, the input register holds
// its byte and in_ready drops; nothing is lost.
`default_nettype none

module byte_stream_tokenizer_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [bst_pkg::BYTE_W-1:0]    src_byte,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [bst_pkg::KIND_W-1:0]         tok_kind,
  output logic [bst_pkg::POS_W-1:0]          start_pos,
  output logic [bst_pkg::LEN_W-1:0]          lexeme_len,
  output logic [bst_pkg::LINE_W-1:0]         line_num,
  output logic                               last_of_run
);

  logic                          ireg_valid;
  logic [bst_pkg::BYTE_W-1:0]    ireg_byte;
  logic                          room;
  logic                          consume;
  bst_pkg::scan_out_t            scan_res;
  bst_pkg::tok_t                 out_tok;

  assign consume  = ireg_valid && room;
  assign in_ready = !ireg_valid || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      ireg_valid <= 1'b0;
    end else if (in_ready) begin
      ireg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      ireg_byte <= src_byte;
    end
  end

  bst_scan u_scan (
    .clk  (clk),
    .rst  (rst),
    .step (consume),
    .c    (ireg_byte),
    .res  (scan_res)
  );

  bst_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .wr        (scan_res),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_tok   (out_tok)
  );

  assign tok_kind    = out_tok.kind;
  assign start_pos   = out_tok.start;
  assign lexeme_len  = out_tok.len;
  assign line_num    = out_tok.line;
  assign last_of_run = out_tok.last;

endmodule

`default_nettype wire
